/* sv/mmac_pkg.sv */
// Shared types and constants for the matrix multiply-accumulate block.
// Used by the top level and its port checker; depends on nothing else.
`default_nettype none

package mmac_pkg;

  // Item modes on the input channel.
  typedef enum logic [1:0] {
    MODE_LEFT  = 2'd0,
    MODE_RIGHT = 2'd1,
    MODE_INIT  = 2'd2,
    MODE_EMIT  = 2'd3
  } mode_e;

  // Fixed field widths of the ports.
  localparam int MODE_W  = 2;
  localparam int POS_W   = 5;
  localparam int VALUE_W = 32;
  localparam int SIZE_W  = 6;
  localparam int SUM_W   = 64;

  // Fraction bits of an element; the initial sum is scaled up by this much.
  localparam int FRAC_BITS = 16;

  // Matrix size after reset.
  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd8;

  // Saturation limits of a result.
  localparam logic [SUM_W-1:0] SUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [SUM_W-1:0] SUM_MIN = 64'h8000_0000_0000_0000;

endpackage

`default_nettype wire

/* sv/matrix_multiply_accumulate.sv */
// Matrix multiply-accumulate: three element stores, one shared multiplier
// and a wide accumulator. Depends on mmac_pkg.
//
// Rate: a write item (mode 0, 1, 2) leaves the input free. An emit item stalls
// the input until all multiply-accumulates of its row have left the pipeline;
// one is issued per cycle while the output is not stalled, bounded by the
// single read port of each store and the one multiplier. The row's results
// come out one per column. Reset clears control state and sets the size to 8;
// the stores are not cleared and hold anything until written.
`default_nettype none

module matrix_multiply_accumulate #(
  parameter int MAX_SIZE      = 32,
  parameter int ELEMENT_WIDTH = 32
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  // Configuration
  input  wire                                   matrix_size_we_i,
  input  wire  [mmac_pkg::SIZE_W-1:0]           matrix_size_i,
  // Input channel
  input  wire                                   in_valid_i,
  output logic                                  in_stall_o,
  input  wire  [mmac_pkg::MODE_W-1:0]           mode_i,
  input  wire  [mmac_pkg::POS_W-1:0]            row_index_i,
  input  wire  [mmac_pkg::POS_W-1:0]            col_index_i,
  input  wire  signed [mmac_pkg::VALUE_W-1:0]   element_value_i,
  // Output channel
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output logic [mmac_pkg::POS_W-1:0]            out_row_o,
  output logic [mmac_pkg::POS_W-1:0]            out_col_o,
  output logic signed [mmac_pkg::SUM_W-1:0]     sum_value_o,
  output logic                                  last_in_row_o
);

  localparam int IDX_W   = $clog2(MAX_SIZE);
  localparam int CNT_W   = $clog2(MAX_SIZE + 1);
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int DEPTH   = 2 ** ADDR_W;
  localparam int PROD_W  = 2 * ELEMENT_WIDTH;
  localparam int ACC_RAW = PROD_W + IDX_W + 2;
  localparam int ACC_W   = (ACC_RAW > mmac_pkg::SUM_W) ? ACC_RAW : mmac_pkg::SUM_W + 1;

  // Configuration register and the active size derived from it.
  logic [mmac_pkg::SIZE_W-1:0] size_q;
  logic [CNT_W-1:0]            size_n;
  logic [CNT_W-1:0]            size_m1;

  always_comb begin
    if (size_q == '0) begin
      size_n = CNT_W'(1);
    end else if (32'(size_q) > MAX_SIZE) begin
      size_n = CNT_W'(MAX_SIZE);
    end else begin
      size_n = CNT_W'(size_q);
    end
    size_m1 = size_n - CNT_W'(1);
  end

  // Handshakes.
  logic in_acc;
  logic out_acc;
  logic adv;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  // The compute pipeline moves only when the output register can take a result.
  assign adv     = !out_valid_o || !out_stall_i;

  // Decode of the incoming item.
  mmac_pkg::mode_e in_mode;
  logic            pos_ok;
  logic            row_ok;
  logic            wr_left;
  logic            wr_right;
  logic            wr_init;
  logic            start_emit;
  logic [ADDR_W-1:0] wr_addr;

  assign in_mode = mmac_pkg::mode_e'(mode_i);
  assign pos_ok  = (32'(row_index_i) < MAX_SIZE) && (32'(col_index_i) < MAX_SIZE);
  assign row_ok  = 32'(row_index_i) < 32'(size_n);
  assign wr_addr = {IDX_W'(row_index_i), IDX_W'(col_index_i)};

  always_comb begin
    wr_left    = 1'b0;
    wr_right   = 1'b0;
    wr_init    = 1'b0;
    start_emit = 1'b0;
    unique case (in_mode)
      mmac_pkg::MODE_LEFT:  wr_left    = in_acc && pos_ok;
      mmac_pkg::MODE_RIGHT: wr_right   = in_acc && pos_ok;
      mmac_pkg::MODE_INIT:  wr_init    = in_acc && pos_ok;
      mmac_pkg::MODE_EMIT:  start_emit = in_acc && row_ok;
      default: ;
    endcase
  end

  // Issue sequencer: walks column j and inner index k for the emitted row.
  logic                 busy_q;
  logic [mmac_pkg::POS_W-1:0] row_q;
  logic [IDX_W-1:0]     j_q;
  logic [IDX_W-1:0]     k_q;
  logic                 k_last;
  logic                 j_last;
  logic                 rd_en;
  logic [IDX_W-1:0]     row_idx;

  assign k_last  = CNT_W'(k_q) == size_m1;
  assign j_last  = CNT_W'(j_q) == size_m1;
  assign rd_en   = busy_q && adv;
  assign row_idx = IDX_W'(row_q);

  // Pipeline tags: stage 1 holds read data, stage 2 holds the product.
  logic             s1_v_q, s1_first_q, s1_last_q;
  logic [IDX_W-1:0] s1_col_q;
  logic             s2_v_q, s2_first_q, s2_last_q;
  logic [IDX_W-1:0] s2_col_q;

  assign in_stall_o = busy_q || s1_v_q || s2_v_q;

  // Element stores, each with one write port and one registered read port.
  logic [ELEMENT_WIDTH-1:0] left_mem  [DEPTH];
  logic [ELEMENT_WIDTH-1:0] right_mem [DEPTH];
  logic [ELEMENT_WIDTH-1:0] init_mem  [DEPTH];
  logic signed [ELEMENT_WIDTH-1:0] a_rd_q;
  logic signed [ELEMENT_WIDTH-1:0] b_rd_q;
  logic signed [ELEMENT_WIDTH-1:0] c_rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_left) begin
      left_mem[wr_addr] <= element_value_i[ELEMENT_WIDTH-1:0];
    end
    if (rd_en) begin
      a_rd_q <= left_mem[{row_idx, k_q}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_right) begin
      right_mem[wr_addr] <= element_value_i[ELEMENT_WIDTH-1:0];
    end
    if (rd_en) begin
      b_rd_q <= right_mem[{k_q, j_q}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_init) begin
      init_mem[wr_addr] <= element_value_i[ELEMENT_WIDTH-1:0];
    end
    if (rd_en) begin
      c_rd_q <= init_mem[{row_idx, j_q}];
    end
  end

  // Multiply stage and scaled initial sum.
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  base_q;

  always_ff @(posedge clk_i) begin
    if (adv && s1_v_q) begin
      prod_q <= PROD_W'(a_rd_q) * PROD_W'(b_rd_q);
      base_q <= ACC_W'(c_rd_q) <<< mmac_pkg::FRAC_BITS;
    end
  end

  // Accumulate, then saturate the finished sum to 64 bits.
  logic signed [ACC_W-1:0]           acc_q;
  logic signed [ACC_W-1:0]           acc_d;
  logic [ACC_W-mmac_pkg::SUM_W:0]    acc_top;
  logic [mmac_pkg::SUM_W-1:0]        sat_sum;

  always_comb begin
    acc_d   = (s2_first_q ? base_q : acc_q) + ACC_W'(prod_q);
    acc_top = acc_d[ACC_W-1:mmac_pkg::SUM_W-1];
    if ((&acc_top) || !(|acc_top)) begin
      sat_sum = acc_d[mmac_pkg::SUM_W-1:0];
    end else if (acc_d[ACC_W-1]) begin
      sat_sum = mmac_pkg::SUM_MIN;
    end else begin
      sat_sum = mmac_pkg::SUM_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_v_q) begin
      acc_q <= acc_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (adv && s2_v_q && s2_last_q) begin
      out_row_o     <= row_q;
      out_col_o     <= mmac_pkg::POS_W'(s2_col_q);
      sum_value_o   <= sat_sum;
      last_in_row_o <= CNT_W'(s2_col_q) == size_m1;
    end
  end

  // Sequencer and pipeline tags.
  always_ff @(posedge clk_i) begin
    if (start_emit) begin
      row_q <= row_index_i;
    end
    if (adv) begin
      s1_first_q <= k_q == '0;
      s1_last_q  <= k_last;
      s1_col_q   <= j_q;
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
      s2_col_q   <= s1_col_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= mmac_pkg::SIZE_RESET;
      busy_q      <= 1'b0;
      j_q         <= '0;
      k_q         <= '0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (matrix_size_we_i) begin
        size_q <= matrix_size_i;
      end

      // Start a row, or step k then j while the pipeline advances.
      if (start_emit) begin
        busy_q <= 1'b1;
        j_q    <= '0;
        k_q    <= '0;
      end else if (rd_en) begin
        if (k_last) begin
          k_q <= '0;
          if (j_last) begin
            busy_q <= 1'b0;
          end else begin
            j_q <= j_q + IDX_W'(1);
          end
        end else begin
          k_q <= k_q + IDX_W'(1);
        end
      end

      if (adv) begin
        s1_v_q <= busy_q;
        s2_v_q <= s1_v_q;
      end

      // A finished column enters the output register; a taken item leaves it.
      if (adv && s2_v_q && s2_last_q) begin
        out_valid_o <= 1'b1;
      end else if (out_acc) begin
        out_valid_o <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/mmac_checker.sv */
// Port-level checks for the matrix multiply-accumulate block, bound to its
// top level. Depends on mmac_pkg.
`default_nettype none

module mmac_checker (
  input wire                                 clk_i,
  input wire                                 rst_ni,
  input wire                                 in_valid_i,
  input wire                                 in_stall_o,
  input wire [mmac_pkg::MODE_W-1:0]          mode_i,
  input wire                                 out_valid_o,
  input wire                                 out_stall_i,
  input wire [mmac_pkg::POS_W-1:0]           out_row_o,
  input wire [mmac_pkg::POS_W-1:0]           out_col_o,
  input wire signed [mmac_pkg::SUM_W-1:0]    sum_value_o,
  input wire                                 last_in_row_o
);

  // A waiting result item holds its payload while stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(sum_value_o) && $stable(out_col_o) && $stable(out_row_o))
    else $error("result item changed while stalled");

  // A write item starts no work, so the input is free again next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (mode_i != mmac_pkg::MODE_EMIT) |=> !in_stall_o)
    else $error("write item left the block busy");

  // While a row is still being emitted, the input stays stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_in_row_o |-> in_stall_o)
    else $error("input free before the row was complete");

  // Columns of one row never come back to back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_in_row_o |=> !out_valid_o)
    else $error("next column arrived too early");

endmodule

bind matrix_multiply_accumulate mmac_checker u_mmac_checker (.*);

`default_nettype wire
